[sv/hgf_pkg.sv]
// Shared constants, types and tables for the Helmholtz Green's function unit.
package hgf_pkg;

  // Default configuration of the datapath.
  localparam int CordicStepsDef = 16;
  localparam int FracBitsDef    = 16;

  // Fixed field widths.
  localparam int InW       = 24;
  localparam int OutW      = 32;
  localparam int DividendW = 64;
  localparam int DivStages = DividendW;

  // Phase scale round(2^48 / (2 pi)), split into two 24-bit halves.
  localparam logic [47:0] PhC   = 48'd44798133900178;
  localparam logic [23:0] PhCHi = PhC[47:24];
  localparam logic [23:0] PhCLo = PhC[23:0];

  // round(2^32 / (4 pi)).
  localparam logic [28:0] C4 = 29'd341782638;

  // CORDIC start value, the inverse gain in Q1.30.
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // Arctangent table in 2^-32 turns.
  function automatic logic [31:0] atan_turns(input int unsigned idx);
    logic [31:0] val;
    unique case (idx)
      0:  val = 32'd536870912;
      1:  val = 32'd316933406;
      2:  val = 32'd167458907;
      3:  val = 32'd85004756;
      4:  val = 32'd42667331;
      5:  val = 32'd21354465;
      6:  val = 32'd10679838;
      7:  val = 32'd5340245;
      8:  val = 32'd2670163;
      9:  val = 32'd1335087;
      10: val = 32'd667544;
      11: val = 32'd333772;
      12: val = 32'd166886;
      13: val = 32'd83443;
      14: val = 32'd41722;
      15: val = 32'd20861;
      16: val = 32'd10430;
      17: val = 32'd5215;
      18: val = 32'd2608;
      19: val = 32'd1304;
      20: val = 32'd652;
      21: val = 32'd326;
      22: val = 32'd163;
      23: val = 32'd81;
      24: val = 32'd41;
      25: val = 32'd20;
      26: val = 32'd10;
      27: val = 32'd5;
      28: val = 32'd3;
      29: val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

  // One finished result.
  typedef struct packed {
    logic signed [OutW-1:0] real_part;
    logic signed [OutW-1:0] imag_part;
    logic                   saturated;
  } hgf_res_t;

endpackage

[sv/hgf_if.sv]
// Channel interfaces for operands and results.
interface hgf_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] wavenumber;
  logic [23:0] distance;

  modport source (output valid, output wavenumber, output distance, input ready);
  modport sink   (input valid, input wavenumber, input distance, output ready);
endinterface

interface hgf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] real_part;
  logic signed [31:0] imag_part;
  logic               saturated;

  modport source (output valid, output real_part, output imag_part, output saturated,
                  input ready);
  modport sink   (input valid, input real_part, input imag_part, input saturated,
                  output ready);
endinterface

[sv/hgf_front.sv]
// Front end: operand capture, zero-distance classification, phase and k squared.
module hgf_front import hgf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hgf_in_if.sink               in_i,
  input  logic                 ready_i,
  output logic                 valid_o,
  output logic                 zero_o,
  output logic [DividendW-1:0] dividend_o,
  output logic [InW-1:0]       divisor_o,
  output logic [31:0]          phase_o
);

  logic           valid1_q;
  logic           zero1_q;
  logic [InW-1:0] k1_q, r1_q;
  logic [47:0]    kk2_q, p2_q;
  logic [InW-1:0] r2_q;
  logic [47:0]    hh3_q, hl3_q, lh3_q, ll3_q;
  logic [31:0]    phase4_q;
  logic [48:0]    mid;
  logic [48:0]    t_sum;
  logic [31:0]    carry;

  assign in_i.ready = ready_i;

  // Capture stage: the valid flag is control, the operands are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= in_i.valid && in_i.ready;
    end
  end

  always_ff @(posedge clk_i) begin
    k1_q    <= in_i.wavenumber;
    r1_q    <= in_i.distance;
    zero1_q <= (in_i.distance == '0);
  end

  // Products k*r and k*k.
  always_ff @(posedge clk_i) begin
    kk2_q <= k1_q * k1_q;
    p2_q  <= k1_q * r1_q;
    r2_q  <= r1_q;
  end

  // Partial products of k*r times the phase scale.
  always_ff @(posedge clk_i) begin
    hh3_q <= p2_q[47:24] * PhCHi;
    hl3_q <= p2_q[47:24] * PhCLo;
    lh3_q <= p2_q[23:0]  * PhCHi;
    ll3_q <= p2_q[23:0]  * PhCLo;
  end

  // Phase in turns: bits 48 and up of the full product, modulo 2^32.
  always_comb begin
    mid   = {1'b0, hl3_q} + {1'b0, lh3_q};
    t_sum = {1'b0, ll3_q} + {1'b0, mid[23:0], 24'd0};
    carry = {7'd0, mid[48:24]} + {31'd0, t_sum[48]};
  end

  always_ff @(posedge clk_i) begin
    phase4_q <= hh3_q[31:0] + carry;
  end

  assign valid_o    = valid1_q;
  assign zero_o     = zero1_q;
  assign dividend_o = {kk2_q, 16'd0};
  assign divisor_o  = r2_q;
  assign phase_o    = phase4_q;

endmodule

[sv/hgf_cordic.sv]
// Pipelined CORDIC rotator giving rounded cosine and sine of a phase in turns.
module hgf_cordic import hgf_pkg::*; #(
  parameter int STEPS = CordicStepsDef,
  parameter int FRAC  = FracBitsDef
) (
  input  logic                  clk_i,
  input  logic [31:0]           phase_i,
  output logic signed [FRAC+1:0] cos_o,
  output logic signed [FRAC+1:0] sin_o
);

  localparam int TW = FRAC + 2;
  localparam logic signed [33:0] Rnd = 34'sd1 <<< (29 - FRAC);

  logic signed [33:0] x_q [STEPS+1];
  logic signed [33:0] y_q [STEPS+1];
  logic signed [33:0] z_q [STEPS+1];
  logic               flip_q [STEPS+1];

  logic [31:0]        ph_fold;
  logic [31:0]        ph_rot;
  logic               flip;
  logic signed [33:0] xf, yf, xr, yr;
  logic signed [TW-1:0] cs_q, sn_q;

  // Quadrant fold: phases in the left half-plane are turned by half a turn.
  always_comb begin
    ph_fold = phase_i + 32'h4000_0000;
    flip    = ph_fold[31];
    ph_rot  = flip ? phase_i + 32'h8000_0000 : phase_i;
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= CordicGain;
    y_q[0]    <= '0;
    z_q[0]    <= $signed({{2{ph_rot[31]}}, ph_rot});
    flip_q[0] <= flip;
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [33:0] Ang = $signed({2'b00, atan_turns(i)});
    always_ff @(posedge clk_i) begin
      if (!z_q[i][33]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - Ang;
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + Ang;
      end
      flip_q[i+1] <= flip_q[i];
    end
  end

  // Undo the fold and round to FRAC fraction bits, half up.
  always_comb begin
    xf = flip_q[STEPS] ? -x_q[STEPS] : x_q[STEPS];
    yf = flip_q[STEPS] ? -y_q[STEPS] : y_q[STEPS];
    xr = (xf + Rnd) >>> (30 - FRAC);
    yr = (yf + Rnd) >>> (30 - FRAC);
  end

  always_ff @(posedge clk_i) begin
    cs_q <= xr[TW-1:0];
    sn_q <= yr[TW-1:0];
  end

  assign cos_o = cs_q;
  assign sin_o = sn_q;

endmodule

[sv/hgf_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module hgf_div import hgf_pkg::*; (
  input  logic                 clk_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [InW-1:0]       divisor_i,
  output logic [DividendW-1:0] quotient_o
);

  // The numerator register shifts dividend bits out and quotient bits in.
  logic [DividendW-1:0] num_q [DivStages];
  logic [InW-1:0]       rem_q [DivStages];
  logic [InW-1:0]       den_q [DivStages];

  for (genvar j = 0; j < DivStages; j++) begin : g_stage
    logic [DividendW-1:0] num_in;
    logic [InW-1:0]       rem_in;
    logic [InW-1:0]       den_in;
    logic [InW:0]         trial;
    logic [InW:0]         diff;
    logic                 ge;

    if (j == 0) begin : g_first
      assign num_in = dividend_i;
      assign rem_in = '0;
      assign den_in = divisor_i;
    end else begin : g_next
      assign num_in = num_q[j-1];
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
    end

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
      trial = {rem_in, num_in[DividendW-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i) begin
      num_q[j] <= {num_in[DividendW-2:0], ge};
      rem_q[j] <= ge ? diff[InW-1:0] : trial[InW-1:0];
      den_q[j] <= den_in;
    end
  end

  assign quotient_o = num_q[DivStages-1];

endmodule

[sv/hgf_queue.sv]
// Result queue with a registered head that drives the output channel.
module hgf_queue import hgf_pkg::*; #(
  parameter int DEPTH = 80
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  hgf_res_t  data_i,
  hgf_out_if.source out_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);

  hgf_res_t      mem [DEPTH];
  hgf_res_t      head_q;
  logic          head_valid_q, head_valid_d;
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  // Load the head whenever it is empty or being taken.
  assign pop = (cnt_q != '0) && (!head_valid_q || out_o.ready);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - CW'(1);
    end
    if (pop) begin
      head_valid_d = 1'b1;
    end else if (out_o.ready) begin
      head_valid_d = 1'b0;
    end else begin
      head_valid_d = head_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      cnt_q        <= '0;
      head_valid_q <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      head_valid_q <= head_valid_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
      end
    end
  end

  // Storage array with a registered read into the head.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
    if (pop) begin
      head_q <= mem[rd_ptr_q];
    end
  end

  assign out_o.valid     = head_valid_q;
  assign out_o.real_part = head_q.real_part;
  assign out_o.imag_part = head_q.imag_part;
  assign out_o.saturated = head_q.saturated;

endmodule

[sv/helmholtz_3d_green_function_unit.sv]
// Top level of the Helmholtz 3D Green's function unit.
//
// Operands (wavenumber k, distance r, unsigned Q8.16) arrive on in_i and
// results (k^2 cos(kr)/(4 pi r), k^2 sin(kr)/(4 pi r), signed Q16.16, and a
// saturation flag) leave on out_o; both are valid/ready channels and a
// transaction happens when valid and ready are both high.
// One operand transaction can be taken every clock cycle while in_i.ready is
// high. The front end and the arithmetic pipeline never stall; the operands of
// a transaction pass through the front-end stages, the 64-stage restoring
// divider that forms k^2/r, one quotient bit per stage, and the amplitude and
// scaling stages, and the result then goes through the queue to out_o. The
// CORDIC runs alongside the divider and is not on the critical path.
// A zero distance gives zero parts and a clear flag.
// When the receiver stalls, results collect in a queue behind the output
// register; in_i.ready drops once the count of accepted but undelivered
// transactions reaches the queue capacity, so nothing is lost.
// Reset clears all control state: the queue is empty and out_o.valid is low.
module helmholtz_3d_green_function_unit import hgf_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef,
  parameter int FRAC_BITS    = FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hgf_in_if.sink    in_i,
  hgf_out_if.source out_o
);

  localparam int TW      = FRAC_BITS + 2;
  localparam int LatQ    = 2 + DivStages;          // quotient ready
  localparam int LatA    = LatQ + 2;               // amplitude ready
  localparam int Lat     = LatA + 2;               // result ready for the queue
  localparam int PhDelay = LatQ - 4 - CORDIC_STEPS;
  localparam int Cap     = Lat + 8;
  localparam int OW      = $clog2(Cap + 1);
  localparam int HiW     = 29 + TW;
  localparam int LoW     = 32 + TW + 1;
  localparam int VW      = TW + 38;
  localparam int MW      = VW - (FRAC_BITS - 8);
  localparam logic [LoW-1:0] RndLo = LoW'(1) << (FRAC_BITS + 15);
  localparam logic [MW-1:0]  LimPos = MW'(32'h7FFF_FFFF);
  localparam logic [MW-1:0]  LimNeg = MW'(32'h8000_0000);

  logic                 f_valid, f_zero;
  logic [DividendW-1:0] f_dividend;
  logic [InW-1:0]       f_divisor;
  logic [31:0]          f_phase;
  logic [DividendW-1:0] quot;
  logic signed [TW-1:0] cs, sn;

  logic [OW-1:0]        outst_q, outst_d;
  logic                 in_ok, acc, deliver;

  logic                 vld_q  [Lat-1];
  logic                 zero_q [Lat-1];
  logic [31:0]          ph_q   [PhDelay];

  logic [60:0]          am_hi_q, am_lo_q;
  logic [60:0]          a_q;
  logic signed [TW-1:0] trig [2];
  logic [TW-1:0]        mabs [2];
  logic                 neg_q [2];
  logic [HiW-1:0]       hi_q [2];
  logic [LoW-1:0]       lo_q [2];
  logic [VW-1:0]        v [2];
  logic [MW-1:0]        mag [2];
  logic [MW-1:0]        mag_s [2];
  logic [MW-1:0]        sgn [2];
  logic                 clip [2];
  hgf_res_t             res_q, push_data;

  // Outstanding transaction count gates the operand channel.
  assign in_ok   = (outst_q < OW'(Cap));
  assign acc     = in_i.valid && in_i.ready;
  assign deliver = out_o.valid && out_o.ready;

  always_comb begin
    outst_d = outst_q;
    if (acc && !deliver) begin
      outst_d = outst_q + OW'(1);
    end else if (!acc && deliver) begin
      outst_d = outst_q - OW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  hgf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .ready_i    (in_ok),
    .valid_o    (f_valid),
    .zero_o     (f_zero),
    .dividend_o (f_dividend),
    .divisor_o  (f_divisor),
    .phase_o    (f_phase)
  );

  hgf_div u_div (
    .clk_i      (clk_i),
    .dividend_i (f_dividend),
    .divisor_i  (f_divisor),
    .quotient_o (quot)
  );

  // Phase delay so that the CORDIC result lines up with the amplitude.
  always_ff @(posedge clk_i) begin
    ph_q[0] <= f_phase;
    for (int i = 1; i < PhDelay; i++) begin
      ph_q[i] <= ph_q[i-1];
    end
  end

  hgf_cordic #(
    .STEPS (CORDIC_STEPS),
    .FRAC  (FRAC_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .phase_i (ph_q[PhDelay-1]),
    .cos_o   (cs),
    .sin_o   (sn)
  );

  // Valid and zero-distance flags travel alongside the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat - 1; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= f_valid;
      for (int i = 1; i < Lat - 1; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q[0] <= f_zero;
    for (int i = 1; i < Lat - 1; i++) begin
      zero_q[i] <= zero_q[i-1];
    end
  end

  // Amplitude k^2/(4 pi r) in Q.32, formed in two halves.
  always_ff @(posedge clk_i) begin
    am_hi_q <= quot[63:32] * C4;
    am_lo_q <= quot[31:0] * C4;
    a_q     <= am_hi_q + {32'd0, am_lo_q[60:32]};
  end

  // Scaling multiplies on the magnitude of each trig value.
  always_comb begin
    trig[0] = cs;
    trig[1] = sn;
    for (int p = 0; p < 2; p++) begin
      mabs[p] = trig[p][TW-1] ? TW'(-trig[p]) : TW'(trig[p]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 2; p++) begin
      neg_q[p] <= trig[p][TW-1];
      hi_q[p]  <= a_q[60:32] * mabs[p];
      lo_q[p]  <= LoW'(a_q[31:0]) * LoW'(mabs[p]) + RndLo;
    end
  end

  // Rounding, saturation and sign restore.
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      v[p]     = ({1'b0, hi_q[p], 8'd0}) + VW'(lo_q[p] >> 24);
      mag[p]   = MW'(v[p] >> (FRAC_BITS - 8));
      clip[p]  = neg_q[p] ? (mag[p] > LimNeg) : (mag[p] > LimPos);
      mag_s[p] = clip[p] ? (neg_q[p] ? LimNeg : LimPos) : mag[p];
      sgn[p]   = neg_q[p] ? -mag_s[p] : mag_s[p];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.real_part <= $signed(sgn[0][OutW-1:0]);
    res_q.imag_part <= $signed(sgn[1][OutW-1:0]);
    res_q.saturated <= clip[0] || clip[1];
  end

  // A zero distance forces an all-zero result.
  assign push_data = zero_q[Lat-2] ? hgf_res_t'('0) : res_q;

  hgf_queue #(
    .DEPTH (Cap)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (vld_q[Lat-2]),
    .data_i (push_data),
    .out_o  (out_o)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the Helmholtz 3D Green's function unit.
`timescale 1ns / 1ps

module tb_top;
  import hgf_pkg::*;

  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 100;
  localparam int IdleLimit   = 5000;

  logic clk_i;
  logic rst_ni;

  hgf_in_if  in_ch ();
  hgf_out_if out_ch ();

  helmholtz_3d_green_function_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Arctangent steps in 2^-32 turns, for the predictor's own CORDIC.
  localparam longint AtanStep [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81, 41,
    20, 10, 5, 3, 1
  };

  hgf_res_t pending_greens[$];
  bit       failed;
  int       burst_left;
  bit       hold_req;
  int       hold_left;
  int       ready_mode;
  int       ready_phase;
  int       idle_count;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Phase of k*r in turns: floor(k*r * PhC / 2^48) mod 2^32.
  function automatic logic [31:0] phase_of(logic [23:0] k, logic [23:0] r);
    logic [47:0] kr;
    logic [95:0] prod;
    kr   = 48'(k) * 48'(r);
    prod = 96'(kr) * 96'(PhC);
    return prod[79:48];
  endfunction

  // Amplitude times one trig value, rounded half away from zero and clipped.
  function automatic logic signed [31:0] scale_trig(longint unsigned amp, longint trig,
                                                    ref bit sat);
    bit              neg;
    longint unsigned mag;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned lim;
    neg = trig < 0;
    mag = neg ? longint'(-trig) : longint'(trig);
    hi  = (amp >> 32) * mag;
    lo  = (amp & 64'hFFFF_FFFF) * mag + (64'd1 << (FracBitsDef + 15));
    mag = ((hi << 8) + (lo >> 24)) >> (FracBitsDef - 8);
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (mag > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return neg ? 32'(-longint'(mag)) : 32'(mag);
  endfunction

  // Expected Green's function value for one pair of operands.
  function automatic hgf_res_t green_of(logic [23:0] k, logic [23:0] r);
    hgf_res_t        res;
    logic [31:0]     ph;
    bit              flip;
    longint          x;
    longint          y;
    longint          z;
    longint          dx;
    longint          dy;
    longint          cs;
    longint          sn;
    longint unsigned q;
    longint unsigned amp;
    bit              sat;
    res = '0;
    if (r == 0) return res;
    // CORDIC on the phase, folded into [-1/4, 1/4) turn.
    ph   = phase_of(k, r);
    flip = ph[31] ^ ph[30];
    if (flip) ph = ph + 32'h8000_0000;
    z = longint'(int'(ph));
    x = CordicGain;
    y = 0;
    for (int i = 0; i < CordicStepsDef && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - AtanStep[i];
      end else begin
        x = x + dx; y = y - dy; z = z + AtanStep[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = (x + (64'sd1 <<< (29 - FracBitsDef))) >>> (30 - FracBitsDef);
    sn = (y + (64'sd1 <<< (29 - FracBitsDef))) >>> (30 - FracBitsDef);
    // Amplitude k^2 / (4 pi r).
    q   = ((64'(k) * 64'(k)) << 16) / 64'(r);
    amp = (q >> 32) * 64'(C4) + (((q & 64'hFFFF_FFFF) * 64'(C4)) >> 32);
    sat = 1'b0;
    res.real_part = scale_trig(amp, cs, sat);
    res.imag_part = scale_trig(amp, sn, sat);
    res.saturated = sat;
    return res;
  endfunction

  // Offer one operand pair and wait for its transaction; gaps come between bursts.
  task automatic send_pair(logic [23:0] k, logic [23:0] r);
    in_ch.valid      <= 1'b1;
    in_ch.wavenumber <= k;
    in_ch.distance   <= r;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_greens.push_back(green_of(k, r));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_greens.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Mixed operands: full range, readable unsaturated ones, tiny or zero distances.
  task automatic send_random_pair();
    logic [23:0] k;
    logic [23:0] r;
    case ($urandom_range(0, 3))
      0: begin
        k = 24'($urandom_range(0, 24'hFF_FFFF));
        r = 24'($urandom_range(0, 24'hFF_FFFF));
      end
      1: begin
        k = 24'($urandom_range(0, 24'h0F_FFFF));
        r = 24'($urandom_range(24'h01_0000, 24'hFF_FFFF));
      end
      2: begin
        k = 24'($urandom_range(0, 24'h00_FFFF));
        r = 24'($urandom_range(1, 24'h00_FFFF));
      end
      default: begin
        k = 24'($urandom_range(0, 24'hFF_FFFF));
        r = ($urandom_range(0, 3) == 0) ? 24'h0 : 24'($urandom_range(1, 24'h00_00FF));
      end
    endcase
    send_pair(k, r);
  endtask

  // Extremes of both operands, zero distance, zero wavenumber and saturation.
  task automatic test_directed();
    send_pair(24'h00_0000, 24'h00_0000);
    send_pair(24'hFF_FFFF, 24'h00_0000);
    send_pair(24'h00_0000, 24'hFF_FFFF);
    send_pair(24'h00_0000, 24'h00_0001);
    send_pair(24'hFF_FFFF, 24'hFF_FFFF);
    send_pair(24'hFF_FFFF, 24'h00_0001);
    send_pair(24'h00_0001, 24'h00_0001);
    send_pair(24'h00_0001, 24'hFF_FFFF);
    send_pair(24'h01_0000, 24'h01_0000);
    send_pair(24'h02_0000, 24'h00_8000);
    send_pair(24'h01_0000, 24'h03_243F);
    send_pair(24'h01_0000, 24'h01_921F);
    send_pair(24'h01_0000, 24'h04_B65F);
    send_pair(24'h10_0000, 24'h00_0100);
    send_pair(24'hAA_AAAA, 24'h55_5555);
    send_pair(24'h55_5555, 24'hAA_AAAA);
    send_pair(24'h80_0000, 24'h80_0000);
    send_pair(24'h7F_FFFF, 24'h00_0010);
    send_pair(24'h00_4000, 24'h12_3456);
    send_pair(24'h03_0000, 24'h00_1000);
    wait_drained();
  endtask

  // Bulk random operands under random sender gaps and receiver stalls.
  task automatic test_random_operands(int count);
    repeat (count) send_random_pair();
  endtask

  // Long receiver hold-off while the sender keeps offering, so the input stalls.
  task automatic test_output_backpressure();
    hold_req <= 1'b1;
    repeat (150) send_random_pair();
    wait_drained();
  endtask

  // Input channel.
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.wavenumber = '0;
    in_ch.distance   = '0;
    failed           = 1'b0;
    burst_left       = 0;
    hold_req         = 1'b0;
    rst_ni           = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_operands(600);
    test_output_backpressure();
    test_random_operands(780);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed && pending_greens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: alternates between always ready and random stalls, plus one long hold.
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    ready_mode   = 0;
    ready_phase  = 0;
  end
  always @(posedge clk_i) begin
    if (ready_phase == 0) begin
      ready_mode  <= $urandom_range(0, 2);
      ready_phase <= $urandom_range(50, 300);
    end else begin
      ready_phase <= ready_phase - 1;
    end
    if (hold_req) begin
      hold_req     <= 1'b0;
      hold_left    <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (ready_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= $urandom_range(0, 3) != 0;
        default: out_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Result checker: each transaction against the oldest expectation.
  always @(posedge clk_i) begin
    hgf_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_greens.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d sat=%0b", $time,
                 out_ch.real_part, out_ch.imag_part, out_ch.saturated);
        failed = 1'b1;
      end else begin
        want = pending_greens.pop_front();
        if (out_ch.real_part !== want.real_part) begin
          $display("%0t: real_part expected %0d actual %0d", $time,
                   want.real_part, out_ch.real_part);
          failed = 1'b1;
        end
        if (out_ch.imag_part !== want.imag_part) begin
          $display("%0t: imag_part expected %0d actual %0d", $time,
                   want.imag_part, out_ch.imag_part);
          failed = 1'b1;
        end
        if (out_ch.saturated !== want.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time,
                   want.saturated, out_ch.saturated);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction while work is outstanding.
  initial idle_count = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (!in_ch.valid && pending_greens.size() == 0)) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

endmodule

[filelist.f]
sv/hgf_pkg.sv
sv/hgf_if.sv
sv/hgf_front.sv
sv/hgf_cordic.sv
sv/hgf_div.sv
sv/hgf_queue.sv
sv/helmholtz_3d_green_function_unit.sv
tb/tb_top.sv
